FILE: sv/lmbcm_pkg.sv
`default_nettype none

package lmbcm_pkg;

	localparam int CMD_W       = 1;
	localparam int X_W         = 5;
	localparam int Y_W         = 4;
	localparam int COLOR_W     = 16;
	localparam int BYTE_W      = 8;
	localparam int ROW_ADDR_W  = 2;
	localparam int PLANE_IDX_W = 2;
	localparam int INTERVAL_W  = 16;

	localparam int LOOP_TIME_W     = 10;
	localparam int CALL_OVERHEAD_W = 8;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 10;

	localparam logic [CMD_W-1:0] CMD_DRAW    = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_LOOP_TIME     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CALL_OVERHEAD = 2'd1;

	localparam logic [LOOP_TIME_W-1:0]     LOOP_TIME_RST     = 10'd200;
	localparam logic [CALL_OVERHEAD_W-1:0] CALL_OVERHEAD_RST = 8'd60;

	// Columns are stored in groups of this many bytes.
	localparam int GROUP_BYTES = 16;
	localparam int OFFSET_W    = 6;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [X_W-1:0]     pixel_x;
		logic [Y_W-1:0]     pixel_y;
		logic [COLOR_W-1:0] color;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]      data_byte;
		logic [ROW_ADDR_W-1:0]  row_address;
		logic [PLANE_IDX_W-1:0] plane_index;
		logic [INTERVAL_W-1:0]  interval;
		logic                   last_byte;
	} out_t;

endpackage

`default_nettype wire

FILE: sv/led_matrix_bcm_scan_driver_top.sv
`default_nettype none
// A refresh word passes through the store's read register and then the output register before
// it shows at the output; the ROW_BYTES words then follow one per cycle while out_ready
// stays high. A draw word takes one read and one write of the single-port store for each
// plane. After reset the frame store is cleared, one byte a cycle, over all
// BANKS * PLANES * ROW_BYTES bytes (1024 by default) before the first word is taken.
module led_matrix_bcm_scan_driver_top #(
	parameter int BANKS     = 4,
	parameter int PLANES    = 4,
	parameter int ROW_BYTES = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output      logic                                  in_ready,
	input  wire lmbcm_pkg::in_t                        in_data,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      lmbcm_pkg::out_t                       out_data,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [lmbcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [lmbcm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lmbcm_pkg::*;

	localparam int PLANE_ROW   = PLANES * ROW_BYTES;
	localparam int STORE_BYTES = BANKS * PLANE_ROW;
	localparam int MW          = $clog2(STORE_BYTES);
	localparam int AXW         = $clog2(STORE_BYTES + 4 * PLANE_ROW + 64);
	localparam int PW          = $clog2(PLANES);
	localparam int BW          = $clog2(BANKS);
	localparam int CW          = $clog2(ROW_BYTES);
	localparam int SUM_W       = LOOP_TIME_W + 2;

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_DRAW_RD = 3'd2;
	localparam logic [2:0] S_DRAW_WR = 3'd3;
	localparam logic [2:0] S_REFRESH = 3'd4;
	localparam logic [2:0] S_DRAIN   = 3'd5;

	logic [2:0] state_q;

	logic [LOOP_TIME_W-1:0]     loop_time_q;
	logic [CALL_OVERHEAD_W-1:0] call_overhead_q;
	logic [PW-1:0]              scan_plane_q;
	logic [BW-1:0]              scan_bank_q;
	logic [ROW_ADDR_W-1:0]      row_latch_q;
	logic [INTERVAL_W-1:0]      interval_q;

	logic [AXW-1:0] addr_q;
	logic [CW-1:0]  cnt_q;
	logic [PW-1:0]  pidx_q;
	logic [3:0]     red_q;
	logic [3:0]     green_q;
	logic [3:0]     blue_q;
	logic           upper_q;

	logic rd_v_s1;
	logic last_s1;
	logic out_valid_q;
	out_t out_q;

	logic              in_acc;
	logic              load_out;
	logic              issue;
	logic              in_range;
	logic              mem_rd;
	logic              mem_wr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [BYTE_W-1:0] mem_rdata;
	logic [AXW-1:0]    addr_next;
	logic [2:0]        bits;

	logic [PW-1:0]         new_plane;
	logic [BW-1:0]         new_bank;
	logic [SUM_W-1:0]      loop_sum;
	logic [INTERVAL_W-1:0] interval_calc;
	logic [AXW-1:0]        refresh_base;
	logic [OFFSET_W-1:0]   col_offset;
	logic [AXW-1:0]        draw_base;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign load_out = rd_v_s1 && (!out_valid_q || out_ready);
	assign issue    = (state_q == S_REFRESH) && (!rd_v_s1 || load_out);
	assign in_range = (addr_q < AXW'(STORE_BYTES));

	// One adder walks the store: by ROW_BYTES to the next plane during a draw, by one byte otherwise.
	assign addr_next = addr_q + ((state_q == S_DRAW_WR) ? AXW'(ROW_BYTES) : AXW'(1));

	// Next plane and bank, and the timer interval from the plane before the advance.
	always_comb begin
		if (scan_plane_q == PW'(PLANES - 1)) begin
			new_plane = '0;
			new_bank  = (scan_bank_q == BW'(BANKS - 1)) ? '0 : scan_bank_q + BW'(1);
		end else begin
			new_plane = scan_plane_q + PW'(1);
			new_bank  = scan_bank_q;
		end
	end

	assign loop_sum      = {1'b0, loop_time_q, 1'b0} + SUM_W'({call_overhead_q, 1'b0});
	assign interval_calc = (INTERVAL_W'(loop_sum) << scan_plane_q)
		- INTERVAL_W'(call_overhead_q);
	assign refresh_base  = AXW'(new_bank) * AXW'(PLANE_ROW) + AXW'(new_plane) * AXW'(ROW_BYTES);

	// Rows in the first half of each group of eight are mirrored within a column group.
	assign col_offset = {in_data.pixel_x[4:3], ~in_data.pixel_y[2],
		in_data.pixel_x[2:0] ^ {3{~in_data.pixel_y[2]}}};
	assign draw_base  = AXW'(in_data.pixel_y[1:0]) * AXW'(PLANE_ROW) + AXW'(col_offset);

	assign bits = {blue_q[0], green_q[0], red_q[0]};

	always_comb begin
		if (upper_q) begin
			mem_wdata = {mem_rdata[7:5], bits, mem_rdata[1:0]};
		end else begin
			mem_wdata = {bits, mem_rdata[4:0]};
		end
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_wr = 1'b1;
				mem_wdata = '0;
			end
			S_DRAW_RD: mem_rd = in_range;
			S_DRAW_WR: mem_wr = in_range;
			S_REFRESH: mem_rd = issue;
			S_IDLE, S_DRAIN: ;
			default: ;
		endcase
	end

	lmbcm_store #(
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.rd_en(mem_rd),
		.wr_en(mem_wr),
		.addr (addr_q[MW-1:0]),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_time_q     <= LOOP_TIME_RST;
			call_overhead_q <= CALL_OVERHEAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOOP_TIME:     loop_time_q <= cfg_data;
				REG_CALL_OVERHEAD: call_overhead_q <= cfg_data[CALL_OVERHEAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			cnt_q        <= '0;
			pidx_q       <= '0;
			scan_plane_q <= PW'(PLANES - 1);
			scan_bank_q  <= BW'(BANKS - 1);
			row_latch_q  <= '0;
			rd_v_s1      <= 1'b0;
		end else begin
			rd_v_s1 <= issue || (rd_v_s1 && !load_out);
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_next;
					if (addr_q == AXW'(STORE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.command == CMD_REFRESH) begin
							scan_plane_q <= new_plane;
							scan_bank_q  <= new_bank;
							if (new_plane == PW'(1)) begin
								row_latch_q <= ROW_ADDR_W'(new_bank);
							end
							addr_q  <= refresh_base;
							cnt_q   <= '0;
							state_q <= S_REFRESH;
						end else begin
							addr_q  <= draw_base;
							pidx_q  <= '0;
							state_q <= S_DRAW_RD;
						end
					end
				end
				S_DRAW_RD: state_q <= S_DRAW_WR;
				S_DRAW_WR: begin
					addr_q <= addr_next;
					pidx_q <= pidx_q + PW'(1);
					if (pidx_q == PW'(PLANES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DRAW_RD;
					end
				end
				S_REFRESH: begin
					if (issue) begin
						addr_q <= addr_next;
						cnt_q  <= cnt_q + CW'(1);
						if (cnt_q == CW'(ROW_BYTES - 1)) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					// The last word must leave the store's read register before it is reused.
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.command == CMD_REFRESH) begin
			interval_q <= interval_calc;
		end
		if (in_acc && in_data.command == CMD_DRAW) begin
			red_q   <= in_data.color[15:12];
			green_q <= in_data.color[10:7];
			blue_q  <= in_data.color[4:1];
			upper_q <= ~in_data.pixel_y[3];
		end else if (state_q == S_DRAW_WR) begin
			// Planes past the fourth shift in zeros.
			red_q   <= {1'b0, red_q[3:1]};
			green_q <= {1'b0, green_q[3:1]};
			blue_q  <= {1'b0, blue_q[3:1]};
		end
		if (issue) begin
			last_s1 <= (cnt_q == CW'(ROW_BYTES - 1));
		end
		if (load_out) begin
			out_q.data_byte   <= mem_rdata;
			out_q.row_address <= row_latch_q;
			out_q.plane_index <= PLANE_IDX_W'(scan_plane_q);
			out_q.interval    <= interval_q;
			out_q.last_byte   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: sv/lmbcm_store.sv
`default_nettype none

module lmbcm_store #(
	parameter int DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              rd_en,
	input  wire logic                              wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]          addr,
	input  wire logic [lmbcm_pkg::BYTE_W-1:0]      wdata,
	output      logic [lmbcm_pkg::BYTE_W-1:0]      rdata
);
	import lmbcm_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// Single port; the read word holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
